FILE: design/bmv_pkg.sv
`timescale 1ns / 1ps
package bmv_pkg;
  localparam int unsigned MaxColsDefault = 8192;
  localparam int unsigned ColCountW = 14;
  localparam int unsigned RowCountW = 16;
  localparam int unsigned CfgIndexW = 1;
  localparam logic [CfgIndexW-1:0] RegColCount = 1'b0;
  localparam logic [CfgIndexW-1:0] RegRowCount = 1'b1;
  localparam logic OpLoad = 1'b0;
  localparam logic OpWeight = 1'b1;
  localparam logic [31:0] QuietNan = 32'h7FC00000;

  // exact bf16 x bf16 product rounded to fp32 (RNE, subnormals kept)
  typedef struct packed {
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic signed [10:0] exp;  // unbiased-ish: value = man * 2^(exp-127-14)
    logic [15:0] man;         // 8x8 product, top at bit 15 or 14
  } prod_t;

  typedef struct packed {
    logic        valid;
    logic        last_col;
    logic        emit;
    logic [15:0] row;
    logic        last_row;
  } ctl_t;

  function automatic logic [31:0] fp_round_pack(input logic sign, input logic signed [11:0] e,
                                                input logic [27:0] m);
    // m: value = m * 2^(e-127-27), m normalized with bit 27 set or zero; bias aware
    logic [27:0] mm;
    logic signed [11:0] ee;
    logic [5:0] sh;
    logic [27:0] shifted;
    logic sticky;
    logic [24:0] r;
    logic [31:0] res;
    mm = m;
    ee = e;
    sticky = 1'b0;
    if (mm == 28'd0) begin
      res = {sign, 31'd0};
    end else begin
      if (ee < 12'sd1) begin
        sh = (12'sd1 - ee > 12'sd28) ? 6'd28 : 6'(12'sd1 - ee);
        shifted = mm >> sh;
        sticky = |(mm & ((28'd1 << sh) - 28'd1));
        mm = shifted;
        ee = 12'sd0;
      end
      // keep 24 bits + guard, round
      r = {1'b0, mm[27:4]};
      if (mm[3] && (mm[2] || mm[1] || mm[0] || sticky || mm[4])) r = r + 25'd1;
      if (r[24]) begin
        r = r >> 1;
        ee = ee + 12'sd1;
      end else if (ee == 12'sd0 && r[23]) begin
        ee = 12'sd1;
      end
      if (ee >= 12'sd255) res = {sign, 8'hFF, 23'd0};
      else res = {sign, ee[7:0], r[22:0]};
    end
    return res;
  endfunction
endpackage

FILE: design/bmv_mul.sv
`timescale 1ns / 1ps
module bmv_mul
  import bmv_pkg::*;
(
  input  logic        clk,
  input  logic [15:0] w,
  input  logic [15:0] x,
  output logic [31:0] prod
);
  logic [7:0] ma, mb;
  logic signed [11:0] ea, eb, es;
  logic [15:0] pm;
  logic [27:0] nm;
  logic [4:0] lz;
  logic sgn, nan_c, inf_c;
  logic [31:0] res;

  always_comb begin
    ma = {(w[14:7] != 8'd0), w[6:0]};
    mb = {(x[14:7] != 8'd0), x[6:0]};
    ea = (w[14:7] == 8'd0) ? 12'sd1 : 12'($unsigned(w[14:7]));
    eb = (x[14:7] == 8'd0) ? 12'sd1 : 12'($unsigned(x[14:7]));
    sgn = w[15] ^ x[15];
    pm = ma * mb;
    lz = 5'd0;
    for (int i = 15; i >= 0; i--) begin
      if (pm[i] && lz == 5'd0) lz = 5'(16 - i);
    end
    // product value = pm * 2^(ea+eb-254-14); place msb at bit 27
    nm = (lz == 5'd0) ? 28'd0 : ({pm, 12'd0} << (lz - 5'd1));
    es = ea + eb - 12'sd127 + 12'sd2 - 12'(lz);
    nan_c = (w[14:7] == 8'hFF && w[6:0] != 7'd0) || (x[14:7] == 8'hFF && x[6:0] != 7'd0) ||
            (w[14:7] == 8'hFF && x[14:0] == 15'd0) || (x[14:7] == 8'hFF && w[14:0] == 15'd0);
    inf_c = (w[14:7] == 8'hFF) || (x[14:7] == 8'hFF);
    if (nan_c) res = QuietNan;
    else if (inf_c) res = {sgn, 8'hFF, 23'd0};
    else res = fp_round_pack(sgn, es, nm);
  end

  always_ff @(posedge clk) prod <= res;
endmodule

FILE: design/bmv_add.sv
`timescale 1ns / 1ps
module bmv_add
  import bmv_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);
  logic [31:0] big, lit;
  logic signed [11:0] eb, el;
  logic [27:0] mbg, mlt, shl, sum;
  logic [8:0] d;
  logic stk, sub;
  logic [4:0] lz;
  logic [28:0] raw;
  logic a_nan, b_nan, a_inf, b_inf;

  always_comb begin
    a_nan = a[30:23] == 8'hFF && a[22:0] != 23'd0;
    b_nan = b[30:23] == 8'hFF && b[22:0] != 23'd0;
    a_inf = a[30:23] == 8'hFF && a[22:0] == 23'd0;
    b_inf = b[30:23] == 8'hFF && b[22:0] == 23'd0;
    if (a[30:0] >= b[30:0]) begin
      big = a; lit = b;
    end else begin
      big = b; lit = a;
    end
    eb = (big[30:23] == 8'd0) ? 12'sd1 : 12'($unsigned(big[30:23]));
    el = (lit[30:23] == 8'd0) ? 12'sd1 : 12'($unsigned(lit[30:23]));
    mbg = {1'b0, big[30:23] != 8'd0, big[22:0], 3'd0};
    mlt = {1'b0, lit[30:23] != 8'd0, lit[22:0], 3'd0};
    d = 9'(eb - el);
    if (d > 9'd27) begin
      shl = 28'd0; stk = mlt != 28'd0;
    end else begin
      shl = mlt >> d[4:0];
      stk = |(mlt & ((28'd1 << d[4:0]) - 28'd1));
    end
    sub = big[31] ^ lit[31];
    raw = sub ? {1'b0, mbg} - {1'b0, shl} - 29'(stk) : {1'b0, mbg} + {1'b0, shl};
    // raw bit 27 overflow position; normalize msb to bit 27
    lz = 5'd0;
    for (int i = 27; i >= 0; i--) begin
      if (raw[i] && lz == 5'd0) lz = 5'(28 - i);
    end
    if (raw[27]) begin
      sum = {raw[27:1], raw[0] | stk};
      s = fp_round_pack(big[31], eb + 12'sd1, sum);
    end else if (raw[27:0] == 28'd0 && !stk) begin
      sum = 28'd0;
      s = {big[31] & lit[31], 31'd0};
    end else begin
      sum = raw[27:0] << (lz - 5'd1);
      s = fp_round_pack(big[31], eb - 12'(lz) + 12'sd2, sum | 28'(stk));
    end
    if (a_nan || b_nan || (a_inf && b_inf && a[31] != b[31])) s = QuietNan;
    else if (a_inf) s = a;
    else if (b_inf) s = b;
  end
endmodule

FILE: design/bf16_matrix_vector_product.sv
`timescale 1ns / 1ps
// Timing: a row's last weight transaction passes through the operand registers (x_q, w_q,
// c1), then the product register and c2, and then the output queue; out_valid rises once the sum is in the queue.
// Throughput: one load or weight transaction per cycle; input stalls only while four
// sums are queued or still in the pipeline behind a stalled output.
// Reset (synchronous, active high) clears counters, accumulator and the output queue and
// sets both counts to one; the vector memory is not cleared and needs no clearing pass.
module bf16_matrix_vector_product
  import bmv_pkg::*;
#(
  parameter int unsigned MAX_COLS = MaxColsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [15:0]          value_bf16,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          sum_fp32,
  output logic [15:0]          row_number,
  output logic                 last_row
);
  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CW = $clog2(MAX_COLS + 1) + 1;
  localparam int unsigned QD = 4;

  logic [15:0] vmem [MAX_COLS];
  logic [ColCountW-1:0] col_count;
  logic [RowCountW-1:0] row_count;
  logic [CW-1:0] cols;
  logic [15:0] rows;
  logic [AW-1:0] load_index, column_index, rd_addr;
  logic [15:0] row_counter, row_cur;
  logic [15:0] x_q, w_q;
  logic [31:0] prod, acc, acc_next, add_s;
  ctl_t c1, c2;
  logic lastc;
  logic [CW-1:0] col_ext;
  logic acc_in, out_fire;
  logic [1:0] q_wp, q_rp;
  logic [2:0] q_cnt, pend;
  logic [31:0] q_sum [QD];
  logic [15:0] q_row [QD];
  logic q_last [QD];
  logic q_wr, q_rd;

  assign cfg_ready = 1'b1;
  // count every sum that is queued or still in the pipeline
  assign pend = q_cnt + 3'(c1.valid && c1.emit) + 3'(c2.valid && c2.emit);
  assign in_ready = pend < 3'(QD);
  assign acc_in = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    cols = (col_count == '0) ? CW'(1) : CW'(col_count);
    if (cols > CW'(MAX_COLS)) cols = CW'(MAX_COLS);
    rows = (row_count == '0) ? 16'd1 : row_count;
    col_ext = CW'(column_index);
    rd_addr = (col_ext >= cols) ? AW'(cols - CW'(1)) : column_index;
    lastc = CW'(rd_addr) + CW'(1) >= cols;
    row_cur = (row_counter >= rows) ? rows - 16'd1 : row_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= ColCountW'(1);
      row_count <= RowCountW'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegColCount: col_count <= cfg_data[ColCountW-1:0];
        RegRowCount: row_count <= cfg_data[RowCountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && op == OpLoad)
      vmem[(CW'(load_index) >= cols) ? AW'(0) : load_index] <= value_bf16;
    x_q <= vmem[rd_addr];
    w_q <= value_bf16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      column_index <= '0;
      row_counter <= '0;
      c1 <= '0;
    end else begin
      c1.valid <= acc_in && op == OpWeight;
      c1.last_col <= lastc;
      c1.emit <= lastc;
      c1.row <= row_cur;
      c1.last_row <= row_cur + 16'd1 >= rows;
      if (acc_in && op == OpLoad) begin
        // an index past a shrunk count writes entry 0 and moves on to entry 1 (entry 0 if the count is one)
        if (CW'(load_index) >= cols) load_index <= (cols > CW'(1)) ? AW'(1) : '0;
        else if (CW'(load_index) + CW'(1) >= cols) load_index <= '0;
        else load_index <= load_index + AW'(1);
      end
      if (acc_in && op == OpWeight) begin
        if (lastc) begin
          column_index <= '0;
          row_counter <= (row_cur + 16'd1 >= rows) ? 16'd0 : row_cur + 16'd1;
        end else begin
          column_index <= rd_addr + AW'(1);
        end
      end
    end
  end

  bmv_mul u_mul (.clk(clk), .w(w_q), .x(x_q), .prod(prod));
  bmv_add u_add (.a(acc), .b(prod), .s(add_s));

  always_comb acc_next = add_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2 <= '0;
      acc <= '0;
    end else begin
      c2 <= c1;
      if (c2.valid) acc <= c2.last_col ? 32'd0 : acc_next;
    end
  end

  assign q_wr = c2.valid && c2.emit;
  assign q_rd = out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wp <= '0;
      q_rp <= '0;
      q_cnt <= '0;
    end else begin
      if (q_wr) q_wp <= q_wp + 2'd1;
      if (q_rd) q_rp <= q_rp + 2'd1;
      q_cnt <= q_cnt + 3'(q_wr) - 3'(q_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr) begin
      q_sum[q_wp] <= (acc_next[30:23] == 8'hFF && acc_next[22:0] != 23'd0) ? QuietNan
                     : acc_next;
      q_row[q_wp] <= c2.row;
      q_last[q_wp] <= c2.last_row;
    end
  end

  assign out_valid = q_cnt != 3'd0;
  assign sum_fp32 = q_sum[q_rp];
  assign row_number = q_row[q_rp];
  assign last_row = q_last[q_rp];
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import bmv_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2000000;
  localparam int unsigned VEC_DEPTH = MaxColsDefault;

  typedef struct {
    logic [31:0] sum;
    logic [15:0] row;
    logic        last;
  } row_sum_t;

  class gemv_scoreboard;
    logic [15:0] vec[VEC_DEPTH];
    int unsigned ld_idx, col_idx, row_idx;
    logic [31:0] acc;
    int unsigned ncols, nrows;
    row_sum_t    sums_due[$];
    int          errors;
    int          sums_seen;

    function new();
      ld_idx = 0; col_idx = 0; row_idx = 0; acc = 32'h0;
      ncols = 1; nrows = 1; errors = 0; sums_seen = 0;
      foreach (vec[i]) vec[i] = 16'h0;
    endfunction

    function int unsigned eff_cols();
      if (ncols == 0) return 1;
      if (ncols > VEC_DEPTH) return VEC_DEPTH;
      return ncols;
    endfunction

    function int unsigned eff_rows();
      return (nrows == 0) ? 1 : nrows;
    endfunction

    function real f32_to_real(logic [31:0] b);
      real r;
      if (b[30:23] == 8'h00) begin
        if (b[22:0] == 23'd0) return $bitstoreal({b[31], 63'd0});
        r = real'(b[22:0]) * (2.0 ** (-149.0));
        return b[31] ? -r : r;
      end
      if (b[30:23] == 8'hFF) begin
        if (b[22:0] != 23'd0) return $bitstoreal(64'h7FF8000000000000);
        return $bitstoreal({b[31], 11'h7FF, 52'd0});
      end
      return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0});
    endfunction

    // round a double to fp32, nearest-even, subnormals kept
    function logic [31:0] real_to_f32(real r);
      logic [63:0] d, mant, kept, rem, half;
      int e, sh;
      logic s;
      d = $realtobits(r);
      s = d[63];
      e = int'(d[62:52]);
      if (e == 2047) return (d[51:0] != 52'd0) ? QuietNan : {s, 8'hFF, 23'd0};
      if (e == 0) return {s, 31'd0};
      e = e - 1023;
      if (e > 127) return {s, 8'hFF, 23'd0};
      mant = {11'd0, 1'b1, d[51:0]};
      sh = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh > 60) sh = 60;
      kept = mant >> sh;
      rem = mant & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
      if (e >= -126) begin
        if (kept[24]) begin
          kept = kept >> 1;
          e = e + 1;
        end
        if (e > 127) return {s, 8'hFF, 23'd0};
        return {s, 8'(e + 127), kept[22:0]};
      end
      return {s, kept[30:0]};
    endfunction

    function void write_reg(logic [CfgIndexW-1:0] idx, logic [31:0] data);
      if (idx == RegColCount) ncols = data[13:0];
      else if (idx == RegRowCount) nrows = data[15:0];
    endfunction

    function void note_input(logic opc, logic [15:0] val);
      int unsigned c, r;
      logic [31:0] prod, s;
      row_sum_t    rs;
      c = eff_cols();
      r = eff_rows();
      if (opc == OpLoad) begin
        if (ld_idx >= c) ld_idx = 0;
        vec[ld_idx] = val;
        ld_idx = (ld_idx + 1 >= c) ? 0 : ld_idx + 1;
        return;
      end
      if (col_idx >= c) col_idx = c - 1;
      prod = real_to_f32(f32_to_real({val, 16'h0}) * f32_to_real({vec[col_idx], 16'h0}));
      acc = real_to_f32(f32_to_real(acc) + f32_to_real(prod));
      if (col_idx + 1 < c) begin
        col_idx++;
        return;
      end
      s = acc;
      if (s[30:23] == 8'hFF && s[22:0] != 23'd0) s = QuietNan;
      if (row_idx >= r) row_idx = r - 1;
      rs.sum = s;
      rs.row = 16'(row_idx);
      rs.last = (row_idx + 1 >= r);
      sums_due.push_back(rs);
      acc = 32'h0;
      col_idx = 0;
      row_idx = rs.last ? 0 : row_idx + 1;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check(logic [31:0] sum, logic [15:0] row, logic last);
      row_sum_t rs;
      sums_seen++;
      if (sums_due.size() == 0) begin
        report($sformatf("unexpected sum %h row %0d", sum, row));
        return;
      end
      rs = sums_due.pop_front();
      if (sum !== rs.sum)
        report($sformatf("row %0d sum %h, want %h", rs.row, sum, rs.sum));
      if (row !== rs.row) report($sformatf("row_number %0d, want %0d", row, rs.row));
      if (last !== rs.last)
        report($sformatf("row %0d last_row %b, want %b", rs.row, last, rs.last));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 op = 1'b0;
  logic [15:0]          value_bf16 = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [31:0]          sum_fp32;
  logic [15:0]          row_number;
  logic                 last_row;

  gemv_scoreboard sb = new();
  int unsigned    cycles = 0;
  bit             calm = 1'b0;
  int unsigned    n_items = 0;
  int unsigned    n_phases = 0;

  bf16_matrix_vector_product i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 21);

  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check(sum_fp32, row_number, last_row);

  task send(logic opc, logic [15:0] val);
    if (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= opc;
    value_bf16 <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_input(opc, val);
    n_items++;
  endtask

  // hold off until every sum has come, then let the pipeline settle
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.sums_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_cfg(logic [CfgIndexW-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task set_shape(logic [13:0] cols, logic [15:0] rows);
    logic [31:0] r1, r2;
    r1 = $urandom;
    r2 = $urandom;
    drain();
    write_cfg(RegColCount, {r1[31:14], cols});
    write_cfg(RegRowCount, {r2[31:16], rows});
    cfg_valid <= 1'b0;
    n_phases++;
  endtask

  function logic [15:0] rand_bf16();
    logic [15:0] v;
    v = 16'($urandom);
    if ($urandom_range(1)) v[14:7] = 8'($urandom_range(134, 120));
    return v;
  endfunction

  // fill every vector entry the current shape reads
  task fill_vector();
    repeat (sb.eff_cols()) send(OpLoad, rand_bf16());
  endtask

  task random_phase(logic [13:0] cols, logic [15:0] rows, int unsigned items);
    set_shape(cols, rows);
    fill_vector();
    repeat (items) begin
      if ($urandom_range(99) < 12) send(OpLoad, rand_bf16());
      else send(OpWeight, rand_bf16());
    end
  endtask

  initial begin
    logic [15:0] dvec[4];
    logic [15:0] dwt[12];
    dvec = '{16'h3F80, 16'h0001, 16'h7F7F, 16'h8000};
    dwt = '{16'h3F80, 16'h3F80, 16'h3F80, 16'hFFFF,
            16'h7F80, 16'h0001, 16'h0000, 16'hFF80,
            16'h0001, 16'h0001, 16'h7F7F, 16'h7FC0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, infinity, NaN, subnormals, overflow
    set_shape(14'd4, 16'd3);
    foreach (dvec[i]) send(OpLoad, dvec[i]);
    foreach (dwt[i]) send(OpWeight, dwt[i]);
    send(OpLoad, 16'h4000);
    repeat (4) send(OpWeight, 16'h7F7F);

    random_phase(14'd5, 16'd3, 150);
    random_phase(14'd0, 16'd0, 50);
    calm = 1'b1;
    random_phase(14'd3, 16'd4, 120);
    calm = 1'b0;
    random_phase(14'd7, 16'd2, 120);
    // pause until every sum is out, then resume mid-row
    drain();
    repeat (40) send(OpWeight, rand_bf16());
    // shrink the row length while a row is half done
    random_phase(14'd2, 16'd5, 120);
    set_shape(14'd1, 16'hFFFF);
    fill_vector();
    repeat (100) send(OpWeight, rand_bf16());
    random_phase(14'd13, 16'd1, 80);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d input transactions over %0d shapes, %0d sums checked",
             n_items, n_phases, sb.sums_seen);
    $display("shapes ranged from zero counts to the largest row count, some changed mid-row");
    if (sb.errors == 0 && sb.sums_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d sums missing", sb.errors, sb.sums_due.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
